>>> rtl/lsbse_pkg.sv
package lsbse_pkg;

   localparam int IV_BYTES    = 16;
   localparam int SALT_BYTES  = 16;
   localparam int BLOCK_BYTES = 16;

   localparam int BLK_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

   localparam logic [31:0] MAGIC_RESET = 32'h0BAD_FACE;

   typedef enum logic [2:0] {
      PH_MAGIC   = 3'd0,
      PH_FLAGS   = 3'd1,
      PH_CYCLES  = 3'd2,
      PH_IV      = 3'd3,
      PH_SALT    = 3'd4,
      PH_LENGTH  = 3'd5,
      PH_CONTENT = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_MISMATCH = 2'd1,
      ST_RAN_OUT  = 2'd2
   } status_type;

   // index of the final byte of each header field
   function automatic logic [4:0] field_last_idx(input phase_type p);
      logic [4:0] r;
      unique case (p)
         PH_MAGIC:  r = 5'd3;
         PH_FLAGS:  r = 5'd3;
         PH_CYCLES: r = 5'd1;
         PH_IV:     r = 5'(IV_BYTES - 1);
         PH_SALT:   r = 5'(SALT_BYTES - 1);
         default:   r = 5'd7;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/lsb_stego_extractor.sv
// Two-bit LSB steganography extractor. Each cover byte (req_kind = 0) gives its low two
// bits, most significant pair first; every fourth cover byte completes one hidden byte,
// which is returned as one response tagged with its header field and byte index, or as
// content with padding and last marks. A magic mismatch, the end of the message or a
// final cover byte that leaves the message unfinished stops the parser until a restart
// request (req_kind = 1), which produces no response. While req_stall is low a request
// is taken every cycle: all parsing is one pass of logic from the parse state into a
// response register, backed by one skid entry; req_stall rises only while that skid
// entry is occupied. Write csr_magic_word only while the block is idle.
module lsb_stego_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_cover_byte,
   input  logic        req_final_cover,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_value,
   output logic [2:0]  rsp_field,
   output logic [4:0]  rsp_header_index,
   output logic        rsp_padding,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_magic_word
);

   typedef struct packed {
      logic [7:0] value;
      logic [2:0] field;
      logic [4:0] header_index;
      logic       padding;
      logic       last;
      logic [1:0] status;
   } res_type;

   logic [31:0]               magic_ff;
   logic [5:0]                acc_ff, acc_in;
   logic [1:0]                pair_ff, pair_in;
   lsbse_pkg::phase_type      phase_ff, phase_in;
   logic [4:0]                fbc_ff, fbc_in;
   logic                      match_ff, match_in;
   logic [63:0]               len_ff, len_in;
   logic [63:0]               remain_ff, remain_in;
   logic [lsbse_pkg::BLK_W-1:0] blk_ff, blk_in;
   logic                      stopped_ff, stopped_in;

   res_type                   main_ff, skid_ff, res;
   logic                      main_valid_ff, skid_valid_ff;

   logic                      accept, have, produce, pop;
   logic [7:0]                byte_v, magic_byte;
   logic                      match_now, pad, reached, blk_end;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;
   assign pop       = main_valid_ff && !rsp_stall;
   assign produce   = accept && have;
   assign csr_ready = 1'b1;

   assign byte_v  = {acc_ff, req_cover_byte[1:0]};
   assign blk_end = (blk_ff == lsbse_pkg::BLK_W'(lsbse_pkg::BLOCK_BYTES - 1));

   always_comb begin
      case (fbc_ff[1:0])
         2'd0:    magic_byte = magic_ff[31:24];
         2'd1:    magic_byte = magic_ff[23:16];
         2'd2:    magic_byte = magic_ff[15:8];
         default: magic_byte = magic_ff[7:0];
      endcase
   end

   always_comb begin
      acc_in     = acc_ff;
      pair_in    = pair_ff;
      phase_in   = phase_ff;
      fbc_in     = fbc_ff;
      match_in   = match_ff;
      len_in     = len_ff;
      remain_in  = remain_ff;
      blk_in     = blk_ff;
      stopped_in = stopped_ff;
      have       = 1'b0;
      res        = '0;
      match_now  = match_ff && (byte_v == magic_byte);
      pad        = (remain_ff == 64'd0);
      reached    = (remain_ff[63:1] == 63'd0);
      if (accept) begin
         if (req_kind) begin
            acc_in     = '0;
            pair_in    = '0;
            phase_in   = lsbse_pkg::PH_MAGIC;
            fbc_in     = '0;
            match_in   = 1'b1;
            len_in     = '0;
            remain_in  = '0;
            blk_in     = '0;
            stopped_in = 1'b0;
         end else if (!stopped_ff) begin
            if (pair_ff != 2'd3) begin
               acc_in  = {acc_ff[3:0], req_cover_byte[1:0]};
               pair_in = pair_ff + 2'd1;
            end else begin
               acc_in    = '0;
               pair_in   = '0;
               have      = 1'b1;
               res.value = byte_v;
               res.field = phase_ff;
               if (phase_ff != lsbse_pkg::PH_CONTENT) begin
                  res.header_index = fbc_ff;
                  if (phase_ff == lsbse_pkg::PH_MAGIC) begin
                     match_in = match_now;
                  end
                  if (phase_ff == lsbse_pkg::PH_LENGTH) begin
                     len_in = {len_ff[55:0], byte_v};
                  end
                  if (fbc_ff == lsbse_pkg::field_last_idx(phase_ff)) begin
                     fbc_in = '0;
                     if (phase_ff == lsbse_pkg::PH_MAGIC && !match_now) begin
                        res.status = lsbse_pkg::ST_MISMATCH;
                        stopped_in = 1'b1;
                     end else if (phase_ff == lsbse_pkg::PH_LENGTH) begin
                        phase_in  = lsbse_pkg::PH_CONTENT;
                        remain_in = {len_ff[55:0], byte_v};
                        blk_in    = '0;
                        // empty message ends on the last length byte
                        if ({len_ff[55:0], byte_v} == 64'd0) begin
                           res.last   = 1'b1;
                           stopped_in = 1'b1;
                        end
                     end else begin
                        phase_in = lsbse_pkg::phase_type'(phase_ff + 3'd1);
                     end
                  end else begin
                     fbc_in = fbc_ff + 5'd1;
                  end
               end else begin
                  res.padding = pad;
                  // stop at the first block boundary at or past the stated length
                  if (reached && blk_end) begin
                     res.last   = 1'b1;
                     stopped_in = 1'b1;
                  end
                  remain_in = pad ? 64'd0 : remain_ff - 64'd1;
                  blk_in    = blk_end ? '0 : blk_ff + lsbse_pkg::BLK_W'(1);
               end
            end
            if (req_final_cover && !stopped_in) begin
               stopped_in = 1'b1;
               res.status = lsbse_pkg::ST_RAN_OUT;
               if (!have) begin
                  have      = 1'b1;
                  res.value = 8'd0;
                  res.field = phase_in;
                  res.header_index = (phase_in != lsbse_pkg::PH_CONTENT) ? fbc_in : 5'd0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff      <= lsbse_pkg::MAGIC_RESET;
         acc_ff        <= '0;
         pair_ff       <= '0;
         phase_ff      <= lsbse_pkg::PH_MAGIC;
         fbc_ff        <= '0;
         match_ff      <= 1'b1;
         len_ff        <= '0;
         remain_ff     <= '0;
         blk_ff        <= '0;
         stopped_ff    <= 1'b0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            magic_ff <= csr_magic_word;
         end
         acc_ff     <= acc_in;
         pair_ff    <= pair_in;
         phase_ff   <= phase_in;
         fbc_ff     <= fbc_in;
         match_ff   <= match_in;
         len_ff     <= len_in;
         remain_ff  <= remain_in;
         blk_ff     <= blk_in;
         stopped_ff <= stopped_in;
         if (skid_valid_ff) begin
            // drain the skid entry into the output register
            if (pop) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (produce) begin
            if (!main_valid_ff || pop) begin
               main_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            main_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (produce) begin
         if (!main_valid_ff || pop) begin
            main_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end
   end

   assign rsp_valid        = main_valid_ff;
   assign rsp_value        = main_ff.value;
   assign rsp_field        = main_ff.field;
   assign rsp_header_index = main_ff.header_index;
   assign rsp_padding      = main_ff.padding;
   assign rsp_last         = main_ff.last;
   assign rsp_status       = main_ff.status;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry occupied while output register is empty");

   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_kind && stopped_ff) |-> !have)
      else $error("response produced while parser is stopped");

   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      (produce && res.last) |=> stopped_ff)
      else $error("parser kept running after the last byte");

   a_mismatch_in_magic: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && main_ff.status == lsbse_pkg::ST_MISMATCH)
      |-> (main_ff.field == lsbse_pkg::PH_MAGIC && !main_ff.last))
      else $error("magic mismatch reported outside the magic field");

   a_content_index_zero: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && main_ff.field == lsbse_pkg::PH_CONTENT)
      |-> (main_ff.header_index == 5'd0))
      else $error("content response carries a header index");

endmodule

>>> tb/sv/tb.sv
module tb;

   localparam int MSG_FULL      = 0;
   localparam int MSG_BAD_MAGIC = 1;
   localparam int MSG_CUT       = 2;
   localparam int MSG_ABORT     = 3;

   typedef struct {
      logic [7:0]           value;
      lsbse_pkg::phase_type  field;
      logic [4:0]           hdr_idx;
      logic                 pad;
      logic                 last;
      lsbse_pkg::status_type status;
   } hidden_rsp_type;

   class hidden_byte_tracker;
      logic [31:0]          magic_word;
      logic [5:0]           pair_bits;
      int                   pairs_held;
      lsbse_pkg::phase_type phase;
      int                   field_pos;
      bit                   magic_ok;
      logic [63:0]          msg_length;
      logic [64:0]          content_seen;
      bit                   halted;
      hidden_rsp_type       due[$];
      int                   errors;

      function new();
         magic_word = lsbse_pkg::MAGIC_RESET;
         errors = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         pair_bits = '0;
         pairs_held = 0;
         phase = lsbse_pkg::PH_MAGIC;
         field_pos = 0;
         magic_ok = 1'b1;
         msg_length = '0;
         content_seen = '0;
         halted = 1'b0;
      endfunction

      function int field_size(lsbse_pkg::phase_type p);
         case (p) inside
            lsbse_pkg::PH_MAGIC, lsbse_pkg::PH_FLAGS: return 4;
            lsbse_pkg::PH_CYCLES:                     return 2;
            lsbse_pkg::PH_IV:                         return lsbse_pkg::IV_BYTES;
            lsbse_pkg::PH_SALT:                       return lsbse_pkg::SALT_BYTES;
            default:                                  return 8;
         endcase
      endfunction

      function int pending();
         return due.size();
      endfunction

      // predict the response (if any) caused by one accepted request
      function void take_cover(logic kind, logic [7:0] cb, logic fin);
         hidden_rsp_type r;
         bit             have;
         logic [7:0]     hb;
         logic [65:0]    next_cnt;
         int             sh;
         have = 1'b0;
         r.value = '0;
         r.field = phase;
         r.hdr_idx = '0;
         r.pad = 1'b0;
         r.last = 1'b0;
         r.status = lsbse_pkg::ST_OK;
         if (kind) begin
            clear_parse();
            return;
         end
         if (halted)
            return;
         if (pairs_held < 3) begin
            pair_bits = {pair_bits[3:0], cb[1:0]};
            pairs_held++;
         end else begin
            hb = {pair_bits, cb[1:0]};
            pair_bits = '0;
            pairs_held = 0;
            have = 1'b1;
            r.value = hb;
            r.field = phase;
            if (phase != lsbse_pkg::PH_CONTENT) begin
               r.hdr_idx = field_pos[4:0];
               if (phase == lsbse_pkg::PH_MAGIC) begin
                  sh = 8 * (3 - (field_pos & 3));
                  if (hb != magic_word[sh +: 8])
                     magic_ok = 1'b0;
               end else if (phase == lsbse_pkg::PH_LENGTH) begin
                  msg_length = {msg_length[55:0], hb};
               end
               field_pos++;
               if (field_pos >= field_size(phase)) begin
                  field_pos = 0;
                  if (phase == lsbse_pkg::PH_MAGIC && !magic_ok) begin
                     r.status = lsbse_pkg::ST_MISMATCH;
                     halted = 1'b1;
                  end else if (phase == lsbse_pkg::PH_LENGTH) begin
                     phase = lsbse_pkg::PH_CONTENT;
                     if (msg_length == '0) begin
                        r.last = 1'b1;
                        halted = 1'b1;
                     end
                  end else begin
                     phase = lsbse_pkg::phase_type'(phase + 1);
                  end
               end
            end else begin
               next_cnt = {1'b0, content_seen} + 66'd1;
               r.pad = (content_seen >= {1'b0, msg_length});
               // end on the block boundary at or past the stated length
               if (next_cnt >= {2'b00, msg_length} &&
                   (next_cnt % lsbse_pkg::BLOCK_BYTES) == 0) begin
                  r.last = 1'b1;
                  halted = 1'b1;
               end
               content_seen = next_cnt[64:0];
            end
         end
         if (fin && !halted) begin
            halted = 1'b1;
            if (!have) begin
               have = 1'b1;
               r.value = '0;
               r.field = phase;
               r.hdr_idx = (phase != lsbse_pkg::PH_CONTENT) ? field_pos[4:0] : 5'd0;
               r.pad = 1'b0;
               r.last = 1'b0;
            end
            r.status = lsbse_pkg::ST_RAN_OUT;
         end
         if (have)
            due.push_back(r);
      endfunction

      function void compare(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t rsp_%s mismatch: expected %0h, got %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void match_byte(logic [7:0] value, logic [2:0] field, logic [4:0] hdr_idx,
                               logic pad, logic last, logic [1:0] status);
         hidden_rsp_type want;
         if (due.size() == 0) begin
            $display("%0t unexpected response: expected none, got value %0h field %0d",
                     $time, value, field);
            errors++;
            return;
         end
         want = due.pop_front();
         compare("value", want.value, value);
         compare("field", want.field, field);
         compare("header_index", want.hdr_idx, hdr_idx);
         compare("padding", want.pad, pad);
         compare("last", want.last, last);
         compare("status", want.status, status);
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [7:0]  req_cover_byte = 8'h00;
   logic        req_final_cover = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_value;
   logic [2:0]  rsp_field;
   logic [4:0]  rsp_header_index;
   logic        rsp_padding;
   logic        rsp_last;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_magic_word = 32'h0;

   hidden_byte_tracker sb = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   int reqs_sent = 0;

   lsb_stego_extractor u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_cover_byte   (req_cover_byte),
      .req_final_cover  (req_final_cover),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_field        (rsp_field),
      .rsp_header_index (rsp_header_index),
      .rsp_padding      (rsp_padding),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_magic_word   (csr_magic_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.match_byte(rsp_value, rsp_field, rsp_header_index, rsp_padding, rsp_last,
                       rsp_status);
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   task automatic send_req(input logic kind, input logic [7:0] cb, input logic fin);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_cover_byte <= cb;
      req_final_cover <= fin;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.take_cover(kind, cb, fin);
      reqs_sent++;
   endtask

   // spread one hidden byte over four cover bytes, most significant pair first
   function automatic void pack_hidden(ref logic [7:0] cq[$], input logic [7:0] hb);
      for (int i = 0; i < 4; i++)
         cq.push_back({6'($urandom), hb[7 - 2 * i -: 2]});
   endfunction

   task automatic send_covers(ref logic [7:0] cq[$], input int n, input bit fin_last);
      for (int k = 0; k < n; k++)
         send_req(1'b0, cq[k], fin_last && (k == n - 1));
   endtask

   task automatic write_magic(input logic [31:0] mw);
      while (sb.pending() != 0)
         @(posedge clock);
      // let any request still in flight settle
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_magic_word <= mw;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      sb.magic_word = mw;
   endtask

   task automatic send_message(input int mode);
      logic [7:0]  covers[$];
      logic [31:0] mw;
      logic [63:0] len;
      int          n_content;
      int          n_send;
      bit          fin_last;
      mw = sb.magic_word;
      if (mode == MSG_BAD_MAGIC)
         mw ^= $urandom_range(0, 1) ? $urandom : (32'h1 << $urandom_range(0, 31));
      if (mode == MSG_CUT) begin
         len = ($urandom_range(0, 3) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom};
         n_content = 40;
      end else begin
         len = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(1, 36));
         n_content = int'((len + lsbse_pkg::BLOCK_BYTES - 1) / lsbse_pkg::BLOCK_BYTES)
                     * lsbse_pkg::BLOCK_BYTES;
      end
      for (int i = 0; i < 4; i++)
         pack_hidden(covers, mw[31 - 8 * i -: 8]);
      repeat (4 + 2 + lsbse_pkg::IV_BYTES + lsbse_pkg::SALT_BYTES)
         pack_hidden(covers, 8'($urandom));
      for (int i = 0; i < 8; i++)
         pack_hidden(covers, len[63 - 8 * i -: 8]);
      repeat (n_content)
         pack_hidden(covers, 8'($urandom));
      case (mode)
         MSG_FULL: begin
            n_send = covers.size();
            fin_last = ($urandom_range(0, 9) < 3);
         end
         MSG_BAD_MAGIC: begin
            n_send = 16 + $urandom_range(0, 8);
            fin_last = ($urandom_range(0, 3) == 0);
         end
         MSG_CUT: begin
            n_send = $urandom_range(1, covers.size());
            fin_last = 1'b1;
         end
         default: begin
            n_send = $urandom_range(1, covers.size() - 1);
            fin_last = 1'b0;
         end
      endcase
      send_req(1'b1, 8'($urandom), 1'($urandom));
      send_covers(covers, n_send, fin_last);
      // trailing junk that a stopped parser must drop
      if (mode == MSG_FULL && $urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3))
            send_req(1'b0, 8'($urandom), 1'($urandom));
   endtask

   initial begin
      logic [7:0] dq[$];
      int         quota;
      int         r;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // restart carries no response even with final set
      send_req(1'b1, 8'hFF, 1'b1);
      // bad magic that also ends the cover: mismatch wins
      pack_hidden(dq, 8'hFF);
      pack_hidden(dq, 8'h00);
      pack_hidden(dq, sb.magic_word[15:8]);
      pack_hidden(dq, 8'h5A);
      send_covers(dq, 16, 1'b1);
      send_req(1'b0, 8'hFF, 1'b1);
      send_req(1'b1, 8'h00, 1'b0);
      // cover runs out in the middle of a hidden byte
      send_req(1'b0, 8'hFF, 1'b0);
      send_req(1'b0, 8'h00, 1'b0);
      send_req(1'b0, 8'h03, 1'b1);
      send_req(1'b1, 8'h55, 1'b1);
      // cover runs out on a completed hidden byte
      dq = {};
      pack_hidden(dq, sb.magic_word[31:24]);
      send_covers(dq, 4, 1'b1);

      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 26 : (p == 1) ? 55 : 0;
         stall_pct = (p == 0) ? 55 : (p == 1) ? 26 : 0;
         req_valid <= 1'b0;
         write_magic((p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'h0000_0000 : $urandom);
         quota = reqs_sent + 200;
         while (reqs_sent < quota) begin
            r = $urandom_range(0, 99);
            send_message(r < 50 ? MSG_FULL : r < 65 ? MSG_BAD_MAGIC :
                         r < 85 ? MSG_CUT : MSG_ABORT);
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
